/* design/ffha_pkg.sv */
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

	localparam int FIELD_W          = 12;
	localparam int HEAP_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 16;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef struct packed {
		logic [FIELD_W-1:0] block_address;
		logic               ok;
	} res_t;

endpackage

/* design/first_fit_heap_allocator_core.sv */
// top level of the first-fit heap allocator with output register
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  request  | in_valid/in_stall  | func, req_size, address
//  result   | out_valid/out_stall| block_address, ok
//
// release: read and write back one header; an address below a header skips both and returns a failed result
// allocate: each header on the walk or merge is read, then inspected, until either reaches the heap end;
//   then decide (or walk on), split where needed, hand over; bound by the single memory read port
// reset: no clearing pass, entry 0 reads as the whole free heap until first written
// one result waits in the output register while the next request is accepted
module first_fit_heap_allocator_core #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [ffha_pkg::FIELD_W-1:0]  req_size,
	input  logic [ffha_pkg::FIELD_W-1:0]  address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ffha_pkg::FIELD_W-1:0]  block_address,
	output logic                          ok
);

	import ffha_pkg::*;

	localparam int AW = $clog2(HEAP_BYTES);

	logic          res_valid;
	res_t          res;
	logic          res_take;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [AW:0]   rd_data;
	logic          we;
	logic [AW-1:0] wr_addr;
	logic [AW:0]   wr_data;

	logic          out_valid_q;
	res_t          out_q;

	assign res_take      = res_valid && (!out_valid_q || !out_stall);
	assign out_valid     = out_valid_q;
	assign block_address = out_q.block_address;
	assign ok            = out_q.ok;

	ffha_hdr_ram #(
		.DEPTH (HEAP_BYTES),
		.AW    (AW),
		.DW    (AW + 1)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ffha_walker #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.AW           (AW)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_stall (in_stall),
		.func      (func),
		.req_size  (req_size),
		.address   (address),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.we        (we),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_take) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/ffha_hdr_ram.sv */
// header store: one write port, one read port with registered read data
module ffha_hdr_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 13
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/ffha_walker.sv */
// header walk, merge, split and release sequencer
module ffha_walker #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16,
	parameter int AW           = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          func,
	input  logic [ffha_pkg::FIELD_W-1:0]  req_size,
	input  logic [ffha_pkg::FIELD_W-1:0]  address,
	output logic                          res_valid,
	output ffha_pkg::res_t                res,
	input  logic                          res_take,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [AW:0]                   rd_data,
	output logic                          we,
	output logic [AW-1:0]                 wr_addr,
	output logic [AW:0]                   wr_data
);

	import ffha_pkg::*;

	localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 2;
	localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
	localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
	localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK_RD,
		S_HEAD,
		S_MERGE_RD,
		S_MERGE,
		S_DECIDE,
		S_SPLIT,
		S_REL_RD,
		S_REL_WR,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [FIELD_W-1:0] req_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      cur_q;
	logic [CW-1:0]      total_q;
	logic [CW-1:0]      rest_q;
	logic [AW-1:0]      rest_size_q;
	res_t               res_q;
	logic               init_q;
	logic               ovr_s1;

	logic [AW:0]   hdr_rd;
	logic          hdr_free;
	logic [CW-1:0] hdr_step;
	logic [CW-1:0] avail;
	logic [CW-1:0] req_ext;
	logic [CW-1:0] split_sz;
	logic [CW-1:0] rest;
	logic          fit;
	logic          do_split;
	logic [CW-1:0] rel_pos;
	logic          rel_ok;

	// entry 0 reads as the whole free heap until first written
	assign hdr_rd   = ovr_s1 ? {1'b1, INIT_SIZE} : rd_data;
	assign hdr_free = hdr_rd[AW];
	assign hdr_step = CW'(hdr_rd[AW-1:0]) + HDR_C;

	assign avail    = total_q - HDR_C;
	assign req_ext  = CW'(req_q);
	assign split_sz = req_ext + HDR_C;
	assign rest     = pos_q + split_sz;
	assign fit      = avail > req_ext;
	assign do_split = (avail > split_sz) && (rest < HEAP_C);

	assign rel_pos = CW'(address) - HDR_C;
	assign rel_ok  = (CW'(address) >= HDR_C) && (rel_pos < HEAP_C);

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q[AW-1:0];
		we      = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = {1'b1, avail[AW-1:0]};
		case (state_q)
			S_WALK_RD: begin
				rd_en = (pos_q < HEAP_C);
			end
			S_MERGE_RD: begin
				rd_en   = (cur_q < HEAP_C);
				rd_addr = cur_q[AW-1:0];
			end
			S_REL_RD: begin
				rd_en = 1'b1;
			end
			S_DECIDE: begin
				we = 1'b1;
				if (fit && do_split) begin
					wr_data = {1'b0, req_ext[AW-1:0]};
				end else if (fit) begin
					wr_data = {1'b0, avail[AW-1:0]};
				end
			end
			S_SPLIT: begin
				we      = 1'b1;
				wr_addr = rest_q[AW-1:0];
				wr_data = {1'b1, rest_size_q};
			end
			S_REL_WR: begin
				we      = 1'b1;
				wr_data = {1'b1, hdr_rd[AW-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			pos_q       <= '0;
			cur_q       <= '0;
			total_q     <= '0;
			rest_q      <= '0;
			rest_size_q <= '0;
			res_q       <= '0;
			init_q      <= 1'b1;
			ovr_s1      <= 1'b0;
		end else begin
			ovr_s1 <= init_q && rd_en && (rd_addr == '0);
			if (we && (wr_addr == '0)) begin
				init_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						res_q <= '0;
						if (func == FUNC_RELEASE) begin
							pos_q   <= rel_pos;
							state_q <= rel_ok ? S_REL_RD : S_DONE;
						end else begin
							pos_q   <= '0;
							req_q   <= req_size;
							state_q <= S_WALK_RD;
						end
					end
				end
				S_WALK_RD: begin
					state_q <= (pos_q < HEAP_C) ? S_HEAD : S_DONE;
				end
				S_HEAD: begin
					if (hdr_free) begin
						total_q <= hdr_step;
						cur_q   <= pos_q + hdr_step;
						state_q <= S_MERGE_RD;
					end else begin
						pos_q   <= pos_q + hdr_step;
						state_q <= S_WALK_RD;
					end
				end
				S_MERGE_RD: begin
					state_q <= (cur_q < HEAP_C) ? S_MERGE : S_DECIDE;
				end
				S_MERGE: begin
					if (hdr_free) begin
						total_q <= total_q + hdr_step;
						cur_q   <= cur_q + hdr_step;
						state_q <= S_MERGE_RD;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (fit) begin
						res_q.block_address <= FIELD_W'(pos_q + HDR_C);
						res_q.ok            <= 1'b1;
						rest_q              <= rest;
						rest_size_q         <= AW'(avail - split_sz);
						state_q             <= do_split ? S_SPLIT : S_DONE;
					end else begin
						pos_q   <= pos_q + total_q;
						state_q <= S_WALK_RD;
					end
				end
				S_SPLIT: begin
					state_q <= S_DONE;
				end
				S_REL_RD: begin
					state_q <= S_REL_WR;
				end
				S_REL_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no read and write of the same entry in one cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && rd_en && (wr_addr == rd_addr)))
		else $error("header read and write collide");

	// a header is only inspected after a read inside the heap
	a_head_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEAD) |-> (pos_q < HEAP_C) && $past(rd_en))
		else $error("header inspected without a read");

	// a merged run holds at least one header
	a_total_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> (total_q >= HDR_C))
		else $error("merged run shorter than a header");

	// once entry 0 is written its reset value is no longer forced
	a_init_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (wr_addr == '0)) |=> !init_q)
		else $error("entry 0 override still active after write");

	// a split remainder always lies inside the heap
	a_split_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT) |-> (rest_q < HEAP_C) && res_q.ok)
		else $error("split remainder outside the heap");

endmodule

/* tb/first_fit_heap_allocator_core_tb.sv */
// testbench for the first-fit heap allocator core, checked against a heap model kept in the bench
`timescale 1ns / 100ps

module first_fit_heap_allocator_core_tb;
	import ffha_pkg::*;

	localparam int HEAP       = HEAP_BYTES_DEF;
	localparam int HDR        = HEADER_BYTES_DEF;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_LEN   = 400;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               func     = FUNC_ALLOC;
	logic [FIELD_W-1:0] req_size = '0;
	logic [FIELD_W-1:0] address  = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [FIELD_W-1:0] block_address;
	logic               ok;

	// heap model: one header per byte offset
	int unsigned blk_size  [HEAP];
	bit          blk_free  [HEAP];
	bit          blk_known [HEAP];
	int unsigned hdr_list[$];
	int unsigned live_blocks[$];
	bit          last_alloc_ok;

	res_t pending_results[$];
	int   fail_count;
	int   burst_left;
	int   idle_cycles;
	int   results_hold_left;
	int   stall_mode;
	int   stall_run;

	first_fit_heap_allocator_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.req_size     (req_size),
		.address      (address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.block_address(block_address),
		.ok           (ok)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_heap_model();
		foreach (blk_size[i]) begin
			blk_size[i]  = 0;
			blk_free[i]  = 1'b0;
			blk_known[i] = 1'b0;
		end
		blk_size[0]  = HEAP - HDR;
		blk_free[0]  = 1'b1;
		blk_known[0] = 1'b1;
		hdr_list     = {0};
		live_blocks  = {};
	endfunction

	// merge the run of free blocks starting at pos, return the merged payload size
	function automatic int unsigned coalesce_from(int unsigned pos);
		int unsigned cur = pos;
		int unsigned total = 0;
		while (cur < HEAP && blk_free[cur]) begin
			total += blk_size[cur] + HDR;
			cur   += blk_size[cur] + HDR;
		end
		if (total > 0) begin
			total -= HDR;
			blk_size[pos] = total;
		end
		return total;
	endfunction

	function automatic res_t heap_outcome(logic f, logic [FIELD_W-1:0] rs, logic [FIELD_W-1:0] ad);
		res_t        r;
		int unsigned need;
		int unsigned pos;
		int unsigned avail;
		int unsigned rest;
		r    = '0;
		need = rs;
		pos  = 0;
		if (f == FUNC_RELEASE) begin
			if (ad >= HDR)
				blk_free[ad - HDR] = 1'b1;
			return r;
		end
		last_alloc_ok = 1'b0;
		while (pos < HEAP) begin
			avail = coalesce_from(pos);
			if (avail > need) begin
				blk_free[pos] = 1'b0;
				if (blk_size[pos] > need + HDR) begin
					rest = pos + need + HDR;
					if (rest < HEAP) begin
						blk_free[rest] = 1'b1;
						blk_size[rest] = avail - need - HDR;
						blk_size[pos]  = need;
						if (!blk_known[rest]) begin
							blk_known[rest] = 1'b1;
							hdr_list.push_back(rest);
						end
					end
				end
				r.block_address = FIELD_W'(pos + HDR);
				r.ok            = 1'b1;
				last_alloc_ok   = 1'b1;
				live_blocks.push_back(pos + HDR);
				return r;
			end
			pos += blk_size[pos] + HDR;
		end
		return r;
	endfunction

	function automatic int unsigned random_size();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(0, 96);
		else if (pick < 90)
			return $urandom_range(97, 600);
		else if (pick < 98)
			return $urandom_range(601, 2000);
		else
			return $urandom_range(2001, 4095);
	endfunction

	task automatic send_request(input logic f, input logic [FIELD_W-1:0] rs,
			input logic [FIELD_W-1:0] ad);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func     <= f;
		req_size <= rs;
		address  <= ad;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(heap_outcome(f, rs, ad));
	endtask

	task automatic alloc_bytes(input int unsigned sz);
		send_request(FUNC_ALLOC, FIELD_W'(sz), FIELD_W'($urandom));
	endtask

	task automatic release_live(input int idx);
		int unsigned a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		send_request(FUNC_RELEASE, FIELD_W'($urandom), FIELD_W'(a));
	endtask

	task automatic pause_requests();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
	endtask

	task automatic wait_all_results();
		pause_requests();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_request();
		int unsigned pick;
		int unsigned h;
		pick = $urandom_range(0, 99);
		if (live_blocks.size() == 0 || pick < 52) begin
			alloc_bytes(random_size());
		end else if (pick < 90) begin
			release_live($urandom_range(0, live_blocks.size() - 1));
		end else if (pick < 95) begin
			// header that may since have been merged away
			h = hdr_list[$urandom_range(0, hdr_list.size() - 1)];
			send_request(FUNC_RELEASE, FIELD_W'($urandom), FIELD_W'(h + HDR));
		end else begin
			send_request(FUNC_RELEASE, FIELD_W'($urandom), FIELD_W'($urandom_range(0, HDR - 1)));
		end
	endtask

	task automatic test_directed();
		alloc_bytes(4095);
		alloc_bytes(HEAP - HDR);
		alloc_bytes(HEAP - HDR - 1);
		alloc_bytes(0);
		release_live(0);
		send_request(FUNC_RELEASE, 12'hfff, 12'd0);
		send_request(FUNC_RELEASE, 12'h000, FIELD_W'(HDR - 1));
		alloc_bytes(0);
		alloc_bytes(HEAP - 2 * HDR - 1);
		release_live(1);
		release_live(0);
		// merge across a zero-size block
		alloc_bytes(100);
		release_live(0);
		alloc_bytes(2100);
		alloc_bytes(5);
		alloc_bytes(30);
		release_live(1);
		release_live(0);
		alloc_bytes(2110);
		alloc_bytes(1000);
		while (live_blocks.size() != 0)
			release_live(live_blocks.size() - 1);
	endtask

	task automatic test_fill_and_fragment();
		int n;
		n = 0;
		do begin
			alloc_bytes($urandom_range(4, 40));
			n++;
		end while (last_alloc_ok && n < 300);
		for (int i = live_blocks.size() - 1; i >= 0; i -= 2)
			release_live(i);
		repeat (40) alloc_bytes($urandom_range(20, 120));
		while (live_blocks.size() != 0)
			release_live($urandom_range(0, live_blocks.size() - 1));
	endtask

	task automatic test_held_results();
		pause_requests();
		@(negedge clk);
		results_hold_left = HOLD_LEN;
		@(posedge clk);
		repeat (12) random_request();
		wait_all_results();
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++)
			random_request();
	endtask

	// result side stall pattern
	always @(posedge clk) begin
		if (results_hold_left != 0) begin
			out_stall <= 1'b1;
			results_hold_left <= results_hold_left - 1;
		end else begin
			if (stall_run == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_run  = $urandom_range(4, 60);
			end
			stall_run--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= $urandom_range(0, 1);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: block_address %0d ok %0b",
					block_address, ok);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (block_address !== want.block_address) begin
					$error("block_address: expected %0d, got %0d", want.block_address,
						block_address);
					fail_count++;
				end
				if (ok !== want.ok) begin
					$error("ok: expected %0b, got %0b", want.ok, ok);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		fail_count        = 0;
		burst_left        = 0;
		idle_cycles       = 0;
		results_hold_left = 0;
		stall_mode        = 0;
		stall_run         = 0;
		last_alloc_ok     = 1'b0;
		reset_heap_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_all_results();
		test_fill_and_fragment();
		wait_all_results();
		test_held_results();
		test_random_mix(1200);
		wait_all_results();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
